[sv/tbt_pkg.sv]
// shared widths, sideband types and the output limit function for two_body_t_range
// no dependencies

package tbt_pkg;

    localparam int IN_W   = 28;   // squared mass / energy field
    localparam int OUT_W  = 31;   // signed t limits
    localparam int LAM_W  = 60;   // signed kallen function and product term
    localparam int MAG_W  = 59;   // kallen magnitude
    localparam int RAD_W  = 118;  // kallen product, radicand of the root
    localparam int ROOT_W = RAD_W / 2;
    localparam int REM_W  = ROOT_W + 1;
    localparam int NUM_W  = 60;   // magnitude of product term +/- root
    localparam int DIV_W  = IN_W + 1;
    localparam int T_W    = 62;

    localparam logic signed [T_W-1:0] T_HI = 62'sd1073741823;
    localparam logic signed [T_W-1:0] T_LO = -62'sd1073741824;

    typedef struct packed {
        logic signed [LAM_W-1:0] prod;
        logic [IN_W-1:0]         s;
        logic [IN_W:0]           base;
        logic                    inv;
    } side_t;

    localparam int SIDE_W = $bits(side_t);

    typedef struct packed {
        logic [IN_W:0] base;
        logic          inv;
        logic          neg;
    } lo_side_t;

    localparam int LO_SIDE_W = $bits(lo_side_t);

    // base - (+/-q), saturated to the output range
    function automatic logic [OUT_W-1:0] tbt_limit(input logic [IN_W:0] base,
                                                   input logic neg,
                                                   input logic [NUM_W-1:0] q);
        logic signed [T_W-1:0] qs;
        logic signed [T_W-1:0] t;
        qs = neg ? -$signed({2'b00, q}) : $signed({2'b00, q});
        t  = $signed({33'd0, base}) - qs;
        if (t > T_HI) begin
            t = T_HI;
        end else if (t < T_LO) begin
            t = T_LO;
        end
        return t[OUT_W-1:0];
    endfunction

endpackage

[sv/tbt_sqrt_cell.sv]
// one digit cell of the integer square root chain, two radicand bits per cell
// depends on tbt_pkg

module tbt_sqrt_cell import tbt_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [RAD_W-1:0]  in_rad,
    input  logic [REM_W-1:0]  in_rem,
    input  logic [ROOT_W-1:0] in_root,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [RAD_W-1:0]  out_rad,
    output logic [REM_W-1:0]  out_rem,
    output logic [ROOT_W-1:0] out_root,
    output logic [SIDE_W-1:0] out_side
);

    logic [REM_W+1:0] rem_sh;
    logic [REM_W+1:0] trial;
    logic [REM_W+1:0] diff;
    logic             ge;

    logic              valid_reg;
    logic [RAD_W-1:0]  rad_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [SIDE_W-1:0] side_reg;

    always_comb begin
        rem_sh = {in_rem, in_rad[RAD_W-1 -: 2]};
        trial  = {1'b0, in_root, 2'b01};
        ge     = (rem_sh >= trial);
        diff   = rem_sh - trial;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rad_reg  <= {in_rad[RAD_W-3:0], 2'b00};
            rem_reg  <= ge ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
            root_reg <= {in_root[ROOT_W-2:0], ge};
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_rad   = rad_reg;
    assign out_rem   = rem_reg;
    assign out_root  = root_reg;
    assign out_side  = side_reg;

endmodule

[sv/tbt_div_cell.sv]
// one bit cell of the restoring divider chain, one quotient bit per cell
// depends on tbt_pkg

module tbt_div_cell import tbt_pkg::*; #(
    parameter int SIDE_W = 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [NUM_W-1:0]  in_dq,
    input  logic [DIV_W-1:0]  in_rem,
    input  logic [DIV_W-1:0]  in_div,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [NUM_W-1:0]  out_dq,
    output logic [DIV_W-1:0]  out_rem,
    output logic [DIV_W-1:0]  out_div,
    output logic [SIDE_W-1:0] out_side
);

    logic [DIV_W:0] r2;
    logic [DIV_W:0] diff;
    logic           ge;

    logic              valid_reg;
    logic [NUM_W-1:0]  dq_reg;
    logic [DIV_W-1:0]  rem_reg;
    logic [DIV_W-1:0]  div_reg;
    logic [SIDE_W-1:0] side_reg;

    always_comb begin
        r2   = {in_rem, in_dq[NUM_W-1]};
        ge   = (r2 >= {1'b0, in_div});
        diff = r2 - {1'b0, in_div};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dq_reg   <= {in_dq[NUM_W-2:0], ge};
            rem_reg  <= ge ? diff[DIV_W-1:0] : r2[DIV_W-1:0];
            div_reg  <= in_div;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_dq    = dq_reg;
    assign out_rem   = rem_reg;
    assign out_div   = div_reg;
    assign out_side  = side_reg;

endmodule

[sv/two_body_t_range.sv]
// top level: t limits of a two-body reaction, kallen functions, root and division chains
// depends on tbt_pkg, tbt_sqrt_cell, tbt_div_cell
//
//   channel   direction  handshake           payload
//   s_        in         s_valid / s_ready   s_mass_a_sq s_mass_b_sq s_mass_one_sq
//                                            s_mass_two_sq s_energy_sq
//   m_        out        m_valid / m_ready   m_t_low_limit m_t_high_limit m_invalid
//
// one transaction per cycle sustained while m_ready is held high; 127 register stages from the
// input capture to m_valid (6 front stages, 59 root cells, 1 stage, 60 divider cells,
// output register)
// the latency is set by the 59-cell root chain and the 60-cell divider chains
// aresetn is synchronous; it clears every valid bit, payload registers are not reset
// a skid register behind the output lets the pipe keep moving for one stalled result;
// when it fills, s_ready drops and the whole pipe holds

module two_body_t_range import tbt_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [IN_W-1:0]         s_mass_a_sq,
    input  logic [IN_W-1:0]         s_mass_b_sq,
    input  logic [IN_W-1:0]         s_mass_one_sq,
    input  logic [IN_W-1:0]         s_mass_two_sq,
    input  logic [IN_W-1:0]         s_energy_sq,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [OUT_W-1:0] m_t_low_limit,
    output logic signed [OUT_W-1:0] m_t_high_limit,
    output logic                    m_invalid
);

    // pipe enable: everything advances while the skid register is empty
    logic en;

    // stage 0: input capture
    logic            v0_reg;
    logic [IN_W-1:0] a0_reg, b0_reg, one0_reg, two0_reg, s0_reg;

    // stage 1: differences and mass products
    logic                   v1_reg;
    logic signed [29:0]     da1_reg, db1_reg, fa1_reg, fb1_reg;
    logic [2*IN_W-1:0]      yza1_reg, yzb1_reg;
    logic [IN_W-1:0]        s1_reg;
    logic [IN_W:0]          base1_reg;
    logic                   z1_reg;

    // stage 2: squares and product term
    logic                    v2_reg;
    logic signed [LAM_W-1:0] sqa2_reg, sqb2_reg, prod2_reg;
    logic [2*IN_W-1:0]       yza2_reg, yzb2_reg;
    logic [IN_W-1:0]         s2_reg;
    logic [IN_W:0]           base2_reg;
    logic                    z2_reg;

    // stage 3: kallen magnitudes and threshold check
    logic                    v3_reg;
    logic [MAG_W-1:0]        maga3_reg, magb3_reg;
    side_t                   side3_reg;
    logic signed [LAM_W-1:0] la_c, lb_c, laa_c, lba_c;
    logic                    neg_c;

    // kallen product, operands split into a 30-bit low part and a 29-bit high part
    logic              vm1_reg;
    logic [59:0]       p00_reg;
    logic [58:0]       p01_reg, p10_reg;
    logic [57:0]       p11_reg;
    side_t             sidem1_reg;
    logic              vm2_reg;
    logic [RAD_W-1:0]  rad_reg;
    side_t             sidem2_reg;
    logic [59:0]       mid_c;

    // root chain
    logic              sq_v    [0:ROOT_W];
    logic [RAD_W-1:0]  sq_rad  [0:ROOT_W];
    logic [REM_W-1:0]  sq_rem  [0:ROOT_W];
    logic [ROOT_W-1:0] sq_root [0:ROOT_W];
    logic [SIDE_W-1:0] sq_side [0:ROOT_W];

    // numerator stage
    side_t             sqe_c;
    logic signed [NUM_W:0] nlo_c, nhi_c, alo_c, ahi_c;
    logic              vd_reg;
    logic [NUM_W-1:0]  mlo_reg, mhi_reg;
    logic [DIV_W-1:0]  dv_reg;
    lo_side_t          lod_reg;
    logic              shi_reg;

    // divider chains
    logic                 lo_v    [0:NUM_W];
    logic [NUM_W-1:0]     lo_dq   [0:NUM_W];
    logic [DIV_W-1:0]     lo_rem  [0:NUM_W];
    logic [DIV_W-1:0]     lo_div  [0:NUM_W];
    logic [LO_SIDE_W-1:0] lo_side [0:NUM_W];
    logic                 hi_v    [0:NUM_W];
    logic [NUM_W-1:0]     hi_dq   [0:NUM_W];
    logic [DIV_W-1:0]     hi_rem  [0:NUM_W];
    logic [DIV_W-1:0]     hi_div  [0:NUM_W];
    logic                 hi_side [0:NUM_W];

    // final limits and output registers
    lo_side_t          loe_c;
    logic [OUT_W-1:0]  tlo_c, thi_c;
    logic              m_valid_reg, skid_valid_reg;
    logic [OUT_W-1:0]  m_tlo_reg, m_thi_reg, skid_tlo_reg, skid_thi_reg;
    logic              m_inv_reg, skid_inv_reg;

    assign en      = !skid_valid_reg;
    assign s_ready = en;

    // valid bits of the front stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg  <= 1'b0;
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            vm1_reg <= 1'b0;
            vm2_reg <= 1'b0;
            vd_reg  <= 1'b0;
        end else if (en) begin
            v0_reg  <= s_valid;
            v1_reg  <= v0_reg;
            v2_reg  <= v1_reg;
            v3_reg  <= v2_reg;
            vm1_reg <= v3_reg;
            vm2_reg <= vm1_reg;
            vd_reg  <= sq_v[ROOT_W];
        end
    end

    // kallen functions: (x-y-z)^2 - 4yz, with a sign flag for the threshold test
    always_comb begin
        la_c  = sqa2_reg - $signed({2'b00, yza2_reg, 2'b00});
        lb_c  = sqb2_reg - $signed({2'b00, yzb2_reg, 2'b00});
        laa_c = la_c[LAM_W-1] ? -la_c : la_c;
        lba_c = lb_c[LAM_W-1] ? -lb_c : lb_c;
        neg_c = (la_c != '0) && (lb_c != '0) && (la_c[LAM_W-1] != lb_c[LAM_W-1]);
        mid_c = {1'b0, p01_reg} + {1'b0, p10_reg};
    end

    // front payload pipeline
    always_ff @(posedge aclk) begin
        if (en) begin
            a0_reg   <= s_mass_a_sq;
            b0_reg   <= s_mass_b_sq;
            one0_reg <= s_mass_one_sq;
            two0_reg <= s_mass_two_sq;
            s0_reg   <= s_energy_sq;

            da1_reg   <= $signed({2'b00, s0_reg}) - $signed({2'b00, a0_reg})
                         - $signed({2'b00, b0_reg});
            db1_reg   <= $signed({2'b00, s0_reg}) - $signed({2'b00, one0_reg})
                         - $signed({2'b00, two0_reg});
            fa1_reg   <= $signed({2'b00, s0_reg}) + $signed({2'b00, a0_reg})
                         - $signed({2'b00, b0_reg});
            fb1_reg   <= $signed({2'b00, s0_reg}) + $signed({2'b00, one0_reg})
                         - $signed({2'b00, two0_reg});
            yza1_reg  <= a0_reg * b0_reg;
            yzb1_reg  <= one0_reg * two0_reg;
            s1_reg    <= s0_reg;
            base1_reg <= {1'b0, a0_reg} + {1'b0, one0_reg};
            z1_reg    <= (s0_reg == '0);

            sqa2_reg  <= da1_reg * da1_reg;
            sqb2_reg  <= db1_reg * db1_reg;
            prod2_reg <= fa1_reg * fb1_reg;
            yza2_reg  <= yza1_reg;
            yzb2_reg  <= yzb1_reg;
            s2_reg    <= s1_reg;
            base2_reg <= base1_reg;
            z2_reg    <= z1_reg;

            maga3_reg      <= laa_c[MAG_W-1:0];
            magb3_reg      <= lba_c[MAG_W-1:0];
            side3_reg.prod <= prod2_reg;
            side3_reg.s    <= s2_reg;
            side3_reg.base <= base2_reg;
            side3_reg.inv  <= z2_reg || neg_c;

            // 59x59 product as four partial products, summed in the following stage (rad_reg)
            p00_reg    <= maga3_reg[29:0] * magb3_reg[29:0];
            p01_reg    <= maga3_reg[29:0] * magb3_reg[58:30];
            p10_reg    <= maga3_reg[58:30] * magb3_reg[29:0];
            p11_reg    <= maga3_reg[58:30] * magb3_reg[58:30];
            sidem1_reg <= side3_reg;

            rad_reg    <= {p11_reg, 60'd0} + {28'd0, mid_c, 30'd0} + {58'd0, p00_reg};
            sidem2_reg <= sidem1_reg;
        end
    end

    // root chain: one root bit per cell
    assign sq_v[0]    = vm2_reg;
    assign sq_rad[0]  = rad_reg;
    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;
    assign sq_side[0] = sidem2_reg;

    for (genvar i = 0; i < ROOT_W; i++) begin : g_sqrt
        tbt_sqrt_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (sq_v[i]),
            .in_rad    (sq_rad[i]),
            .in_rem    (sq_rem[i]),
            .in_root   (sq_root[i]),
            .in_side   (sq_side[i]),
            .out_valid (sq_v[i+1]),
            .out_rad   (sq_rad[i+1]),
            .out_rem   (sq_rem[i+1]),
            .out_root  (sq_root[i+1]),
            .out_side  (sq_side[i+1])
        );
    end

    // numerators P - root and P + root in sign and magnitude
    always_comb begin
        sqe_c = side_t'(sq_side[ROOT_W]);
        nlo_c = $signed({sqe_c.prod[LAM_W-1], sqe_c.prod}) - $signed({2'b00, sq_root[ROOT_W]});
        nhi_c = $signed({sqe_c.prod[LAM_W-1], sqe_c.prod}) + $signed({2'b00, sq_root[ROOT_W]});
        alo_c = nlo_c[NUM_W] ? -nlo_c : nlo_c;
        ahi_c = nhi_c[NUM_W] ? -nhi_c : nhi_c;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mlo_reg      <= alo_c[NUM_W-1:0];
            mhi_reg      <= ahi_c[NUM_W-1:0];
            // divisor 2s; a dummy of one when the item is already invalid
            dv_reg       <= sqe_c.inv ? DIV_W'(1) : {sqe_c.s, 1'b0};
            lod_reg.base <= sqe_c.base;
            lod_reg.inv  <= sqe_c.inv;
            lod_reg.neg  <= nlo_c[NUM_W];
            shi_reg      <= nhi_c[NUM_W];
        end
    end

    // divider chains: magnitude division truncates toward zero
    assign lo_v[0]    = vd_reg;
    assign lo_dq[0]   = mlo_reg;
    assign lo_rem[0]  = '0;
    assign lo_div[0]  = dv_reg;
    assign lo_side[0] = lod_reg;
    assign hi_v[0]    = vd_reg;
    assign hi_dq[0]   = mhi_reg;
    assign hi_rem[0]  = '0;
    assign hi_div[0]  = dv_reg;
    assign hi_side[0] = shi_reg;

    for (genvar j = 0; j < NUM_W; j++) begin : g_div
        tbt_div_cell #(.SIDE_W(LO_SIDE_W)) u_lo (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (lo_v[j]),
            .in_dq     (lo_dq[j]),
            .in_rem    (lo_rem[j]),
            .in_div    (lo_div[j]),
            .in_side   (lo_side[j]),
            .out_valid (lo_v[j+1]),
            .out_dq    (lo_dq[j+1]),
            .out_rem   (lo_rem[j+1]),
            .out_div   (lo_div[j+1]),
            .out_side  (lo_side[j+1])
        );
        tbt_div_cell #(.SIDE_W(1)) u_hi (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (hi_v[j]),
            .in_dq     (hi_dq[j]),
            .in_rem    (hi_rem[j]),
            .in_div    (hi_div[j]),
            .in_side   (hi_side[j]),
            .out_valid (hi_v[j+1]),
            .out_dq    (hi_dq[j+1]),
            .out_rem   (hi_rem[j+1]),
            .out_div   (hi_div[j+1]),
            .out_side  (hi_side[j+1])
        );
    end

    // limits: base - quotient, saturated; zeros when invalid
    always_comb begin
        loe_c = lo_side_t'(lo_side[NUM_W]);
        tlo_c = loe_c.inv ? '0 : tbt_limit(loe_c.base, loe_c.neg, lo_dq[NUM_W]);
        thi_c = loe_c.inv ? '0 : tbt_limit(loe_c.base, hi_side[NUM_W], hi_dq[NUM_W]);
    end

    // output register with skid: a result arriving while the output stalls parks in the skid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (m_ready) begin
                m_valid_reg    <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end else if (lo_v[NUM_W]) begin
            if (!m_valid_reg || m_ready) begin
                m_valid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (m_ready) begin
                m_tlo_reg <= skid_tlo_reg;
                m_thi_reg <= skid_thi_reg;
                m_inv_reg <= skid_inv_reg;
            end
        end else if (lo_v[NUM_W]) begin
            if (!m_valid_reg || m_ready) begin
                m_tlo_reg <= tlo_c;
                m_thi_reg <= thi_c;
                m_inv_reg <= loe_c.inv;
            end else begin
                skid_tlo_reg <= tlo_c;
                skid_thi_reg <= thi_c;
                skid_inv_reg <= loe_c.inv;
            end
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_t_low_limit  = m_tlo_reg;
    assign m_t_high_limit = m_thi_reg;
    assign m_invalid      = m_inv_reg;

    // a parked result always sits behind a shown one
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_valid_reg)
        else $error("skid full while output empty");

    // invalid results carry zero limits
    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_invalid) |-> (m_t_low_limit == '0 && m_t_high_limit == '0))
        else $error("invalid result with nonzero limits");

    // the root is never negative, so t_min never falls below t_max
    a_limit_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_invalid) |-> (m_t_low_limit >= m_t_high_limit))
        else $error("t_min below t_max");

endmodule
